@@ rtl/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned LinkBytes = 8;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned LinkW     = IdxW + 1;
  localparam int unsigned CountW    = 9;
  localparam int unsigned BytesW    = 16;
  localparam int unsigned OffsetW   = 24;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [LinkW-1:0]  EndMark  = LinkW'(MaxBlocks);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxBlocks);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_COUNT = 1'd0,
    CFG_BLOCK_BYTES = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_INIT
  } state_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IdxW-1:0] release_index;
    logic            release_is_null;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdxW-1:0]    block_index;
    logic [OffsetW-1:0] block_offset;
  } out_t;

endpackage

@@ rtl/fbfl_link_mem.sv @@
// ----------------------------------------------------------------------------
// fbfl_link_mem
// Link store: one successor pointer per block, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module fbfl_link_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [fbfl_pkg::IdxW-1:0]   waddr_i,
  input  logic [fbfl_pkg::LinkW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [fbfl_pkg::IdxW-1:0]   raddr_i,
  output logic [fbfl_pkg::LinkW-1:0]  rdata_o
);

  logic [fbfl_pkg::LinkW-1:0] mem_q [fbfl_pkg::MaxBlocks];
  logic [fbfl_pkg::LinkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fixed_block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// LIFO free list of fixed-size blocks; head in a register, links in a RAM.
// ----------------------------------------------------------------------------
//  channel   ports                            beat taken when
//  command   start, busy, in_i                start && !busy
//  result    done_o, res_o                    done_o (one cycle, no stall)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i
//
//  Result is registered: it appears the cycle after the item finishes.
//  Allocate on a non-empty list: registered link RAM read on accept, busy in S_ALLOC.
//  Init: busy in S_INIT while one link is written per cycle, one for each
//  block of the effective count; done straight from S_IDLE if the count is 0.
//  Release, empty allocate, unused mode: done straight from S_IDLE, never busy.
//  Reset leaves the list empty; the link RAM needs no clearing.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  fbfl_pkg::in_t                    in_i,
  output logic                             done_o,
  output fbfl_pkg::out_t                   res_o,
  input  logic                             cfg_we_i,
  input  logic [fbfl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fbfl_pkg::CfgDataW-1:0]    cfg_data_i
);

  fbfl_pkg::state_e              state_q, state_d;
  logic [fbfl_pkg::LinkW-1:0]    head_q, head_d;
  logic [fbfl_pkg::CountW-1:0]   count_q;
  logic [fbfl_pkg::BytesW-1:0]   bytes_q;
  logic [fbfl_pkg::IdxW-1:0]     sweep_q, sweep_d;
  logic [fbfl_pkg::IdxW-1:0]     last_q, last_d;
  logic                          done_q, done_d;
  fbfl_pkg::out_t                res_q, res_d;

  logic                          accept;
  logic [fbfl_pkg::CountW-1:0]   count_eff;
  logic [fbfl_pkg::BytesW:0]     stride;
  logic [fbfl_pkg::OffsetW:0]    product;
  logic                          sweep_end;

  logic                          mem_we, mem_re;
  logic [fbfl_pkg::IdxW-1:0]     mem_waddr, mem_raddr;
  logic [fbfl_pkg::LinkW-1:0]    mem_wdata, mem_rdata;

  assign accept    = start && !busy;
  assign busy      = (state_q != fbfl_pkg::S_IDLE);
  assign count_eff = (count_q > fbfl_pkg::CountMax) ? fbfl_pkg::CountMax : count_q;
  assign stride    = {1'b0, bytes_q} + (fbfl_pkg::BytesW + 1)'(fbfl_pkg::LinkBytes);
  assign product   = (fbfl_pkg::OffsetW + 1)'(head_q[fbfl_pkg::IdxW-1:0])
                   * (fbfl_pkg::OffsetW + 1)'(stride);
  assign sweep_end = (sweep_q == last_q);

  fbfl_link_mem u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= fbfl_pkg::CountMax;
      bytes_q <= fbfl_pkg::BytesW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbfl_pkg::CFG_BLOCK_COUNT: count_q <= cfg_data_i[fbfl_pkg::CountW-1:0];
        fbfl_pkg::CFG_BLOCK_BYTES: bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbfl_pkg::S_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            fbfl_pkg::MODE_ALLOC: begin
              if (!head_q[fbfl_pkg::IdxW]) state_d = fbfl_pkg::S_ALLOC;
            end
            fbfl_pkg::MODE_INIT: begin
              if (count_eff != '0) state_d = fbfl_pkg::S_INIT;
            end
            default: ;
          endcase
        end
      end
      fbfl_pkg::S_ALLOC: state_d = fbfl_pkg::S_IDLE;
      fbfl_pkg::S_INIT: begin
        if (sweep_end) state_d = fbfl_pkg::S_IDLE;
      end
      default: state_d = fbfl_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d    = head_q;
    sweep_d   = sweep_q;
    last_d    = last_q;
    done_d    = 1'b0;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = fbfl_pkg::EndMark;
    mem_raddr = head_q[fbfl_pkg::IdxW-1:0];
    case (state_q)
      fbfl_pkg::S_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            fbfl_pkg::MODE_INIT: begin
              if (count_eff == '0) begin
                head_d = fbfl_pkg::EndMark;
                done_d = 1'b1;
              end else begin
                head_d  = '0;
                sweep_d = '0;
                last_d  = fbfl_pkg::IdxW'(count_eff - fbfl_pkg::CountW'(1));
              end
            end
            fbfl_pkg::MODE_ALLOC: begin
              if (head_q[fbfl_pkg::IdxW]) begin
                res_d.status = fbfl_pkg::STAT_EMPTY;
                done_d       = 1'b1;
              end else begin
                mem_re = 1'b1;
              end
            end
            fbfl_pkg::MODE_RELEASE: begin
              done_d = 1'b1;
              if (in_i.release_is_null) begin
                res_d.status = fbfl_pkg::STAT_NULL;
              end else if ({1'b0, in_i.release_index} >= count_eff) begin
                res_d.status = fbfl_pkg::STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_i.release_index;
                mem_wdata = head_q;
                head_d    = {1'b0, in_i.release_index};
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      fbfl_pkg::S_ALLOC: begin
        head_d             = mem_rdata;
        done_d             = 1'b1;
        res_d.block_index  = head_q[fbfl_pkg::IdxW-1:0];
        res_d.block_offset = product[fbfl_pkg::OffsetW-1:0];
      end
      fbfl_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = sweep_end ? fbfl_pkg::EndMark : ({1'b0, sweep_q} + fbfl_pkg::LinkW'(1));
        sweep_d   = sweep_q + fbfl_pkg::IdxW'(1);
        done_d    = sweep_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbfl_pkg::S_IDLE;
      head_q  <= fbfl_pkg::EndMark;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    sweep_q <= sweep_d;
    last_q  <= last_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_alloc_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbfl_pkg::S_ALLOC |=> done_o)
    else $error("allocate finished without a result beat");

  a_alloc_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.mode == fbfl_pkg::MODE_ALLOC && !head_q[fbfl_pkg::IdxW]
    |=> state_q == fbfl_pkg::S_ALLOC)
    else $error("pop did not wait for the link read");

  a_mem_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("link write and read in the same cycle");

  a_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(head_q[fbfl_pkg::IdxW] && head_q[fbfl_pkg::IdxW-1:0] != '0))
    else $error("head beyond the end mark");

  a_busy_no_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbfl_pkg::S_ALLOC |-> !done_o)
    else $error("result beat overlaps a pending pop");

endmodule

@@ dv/pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_checker
// Watches the command, result and register ports of the block free-list
// allocator. It keeps its own copy of the free-list head, the link table and
// both registers, works out the expected result of every accepted command
// and compares each result beat with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module pool_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  fbfl_pkg::in_t                 cmd_i,
  input  logic                          done_i,
  input  fbfl_pkg::out_t                res_i,
  input  logic                          cfg_we_i,
  input  logic [fbfl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fbfl_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o
);

  logic [fbfl_pkg::CountW-1:0] count_q;
  logic [fbfl_pkg::BytesW-1:0] bytes_q;
  logic [fbfl_pkg::LinkW-1:0]  head_q;
  logic [fbfl_pkg::LinkW-1:0]  link_mem [fbfl_pkg::MaxBlocks];
  fbfl_pkg::out_t              expected_results [$];

  function automatic int unsigned usable_blocks();
    return (count_q > fbfl_pkg::CountMax) ? fbfl_pkg::MaxBlocks : int'(count_q);
  endfunction

  // Applies one command to the shadow pool and returns the answer it gives.
  function automatic fbfl_pkg::out_t pool_step(input fbfl_pkg::in_t c);
    fbfl_pkg::out_t            r;
    int unsigned               n;
    logic [fbfl_pkg::IdxW-1:0] blk;
    r = '0;
    n = usable_blocks();
    case (c.mode)
      fbfl_pkg::MODE_INIT: begin
        for (int unsigned i = 0; i < n; i++) begin
          link_mem[i] = (i + 1 == n) ? fbfl_pkg::EndMark : fbfl_pkg::LinkW'(i + 1);
        end
        head_q = (n == 0) ? fbfl_pkg::EndMark : '0;
      end
      fbfl_pkg::MODE_ALLOC: begin
        if (head_q >= fbfl_pkg::EndMark) begin
          r.status = fbfl_pkg::STAT_EMPTY;
        end else begin
          blk = head_q[fbfl_pkg::IdxW-1:0];
          head_q = link_mem[blk];
          r.status = fbfl_pkg::STAT_OK;
          r.block_index = blk;
          r.block_offset = fbfl_pkg::OffsetW'(32'(blk) *
                                              (32'(bytes_q) + fbfl_pkg::LinkBytes));
        end
      end
      fbfl_pkg::MODE_RELEASE: begin
        if (c.release_is_null) begin
          r.status = fbfl_pkg::STAT_NULL;
        end else if (int'(c.release_index) >= n) begin
          r.status = fbfl_pkg::STAT_RANGE;
        end else begin
          link_mem[c.release_index] = head_q;
          head_q = {1'b0, c.release_index};
          r.status = fbfl_pkg::STAT_OK;
        end
      end
      default: r.status = fbfl_pkg::STAT_OK;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fbfl_pkg::out_t want;
    if (!rst_ni) begin
      count_q = fbfl_pkg::CountMax;
      bytes_q = fbfl_pkg::BytesW'(64);
      head_q = fbfl_pkg::EndMark;
      for (int i = 0; i < fbfl_pkg::MaxBlocks; i++) link_mem[i] = fbfl_pkg::EndMark;
      expected_results.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t pool_checker: unexpected beat: st=%0d idx=%0d off=%0d",
                     $realtime, res_i.status, res_i.block_index, res_i.block_offset);
        end else begin
          want = expected_results.pop_front();
          if (res_i.status !== want.status || res_i.block_index !== want.block_index ||
              res_i.block_offset !== want.block_offset) begin
            errors_o++;
            if (errors_o <= 10)
              $display({"%0t pool_checker: mismatch exp st=%0d idx=%0d off=%0d",
                        " got st=%0d idx=%0d off=%0d"},
                       $realtime, want.status, want.block_index, want.block_offset,
                       res_i.status, res_i.block_index, res_i.block_offset);
          end
        end
      end
      if (start_i && !busy_i) expected_results.push_back(pool_step(cmd_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fbfl_pkg::CFG_BLOCK_COUNT: count_q = cfg_data_i[fbfl_pkg::CountW-1:0];
          fbfl_pkg::CFG_BLOCK_BYTES: bytes_q = cfg_data_i[fbfl_pkg::BytesW-1:0];
          default: ;
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the block free-list allocator: a directed opening (empty pool,
// null and out-of-range releases, double free, zero and two-block pools,
// unused mode), then random command streams over a range of pool sizes and
// block sizes, sent in bursts with random gaps. Checking is in pool_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0]  ModeUnused = 2'd3;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseCmds  = 208;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  fbfl_pkg::in_t                 cmd;
  logic                          done;
  fbfl_pkg::out_t                res;
  logic                          cfg_we;
  logic [fbfl_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [fbfl_pkg::CfgDataW-1:0] cfg_data;
  int unsigned                   errors;
  int unsigned                   pending;
  int unsigned                   stall_cycles;
  int unsigned                   n_by_mode [4];
  int unsigned                   n_settings;

  fixed_block_free_list_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (cmd),
    .done_o     (done),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pool_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .done_i     (done),
    .res_i      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_top: no beat for %0d cycles", StallLimit);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic fbfl_pkg::in_t make_cmd(input logic [1:0] m, input int unsigned idx,
                                             input logic is_null);
    fbfl_pkg::in_t c;
    c.mode = m;
    c.release_index = fbfl_pkg::IdxW'(idx);
    c.release_is_null = is_null;
    return c;
  endfunction

  task automatic send_cmd(input fbfl_pkg::in_t c);
    @(negedge clk_i);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk_i); while (busy);
    n_by_mode[c.mode]++;
  endtask

  task automatic pause(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd <= make_cmd(2'($urandom), $urandom, 1'($urandom));
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input fbfl_pkg::cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= fbfl_pkg::CfgDataW'(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pool(input int unsigned count, input int unsigned bytes);
    write_reg(fbfl_pkg::CFG_BLOCK_COUNT, count);
    write_reg(fbfl_pkg::CFG_BLOCK_BYTES, bytes);
    n_settings++;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned bytes);
    int unsigned   usable;
    int unsigned   alloc_w;
    int unsigned   burst_left;
    int unsigned   p;
    fbfl_pkg::in_t c;
    usable = (count > fbfl_pkg::MaxBlocks) ? fbfl_pkg::MaxBlocks : count;
    alloc_w = $urandom_range(25, 75);
    burst_left = 0;
    set_pool(count, bytes);
    send_cmd(make_cmd(fbfl_pkg::MODE_INIT, $urandom, 1'($urandom)));
    for (int unsigned k = 0; k < PhaseCmds; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        pause(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
      end
      burst_left--;
      p = $urandom_range(0, 99);
      if (p < 2)
        c = make_cmd(fbfl_pkg::MODE_INIT, $urandom, 1'($urandom));
      else if (p < 5)
        c = make_cmd(ModeUnused, $urandom, 1'($urandom));
      else if (p < 10)
        c = make_cmd(fbfl_pkg::MODE_RELEASE, $urandom, 1'b1);
      else if (p < 15)
        c = make_cmd(fbfl_pkg::MODE_RELEASE, $urandom, 1'b0);
      else if ($urandom_range(0, 99) < alloc_w || usable == 0)
        c = make_cmd(fbfl_pkg::MODE_ALLOC, $urandom, 1'($urandom));
      else
        c = make_cmd(fbfl_pkg::MODE_RELEASE, $urandom_range(0, usable - 1), 1'b0);
      send_cmd(c);
    end
    drain();
  endtask

  initial begin
    int unsigned counts [NumPhases];
    int unsigned sizes [NumPhases];
    rst_ni = 1'b0;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    n_settings = 0;
    foreach (n_by_mode[i]) n_by_mode[i] = 0;
    counts = '{256, 1, 511, 3, $urandom_range(1, 256), 16, 256, $urandom_range(2, 64), 300};
    sizes = '{65535, 1, 8, $urandom_range(1, 65535), 64, 65535, 1, $urandom_range(1, 65535),
              $urandom_range(1, 1024)};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset pool: empty list, default sizes
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 255, 1'b1));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 5, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 255, 1'b1));
    send_cmd(make_cmd(ModeUnused, 255, 1'b1));
    send_cmd(make_cmd(fbfl_pkg::MODE_INIT, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 255, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    drain();

    // two-block pool with the widest blocks, range edge and double free
    set_pool(2, 65535);
    send_cmd(make_cmd(fbfl_pkg::MODE_INIT, 255, 1'b1));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 2, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 1, 1'b1));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 1, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 1, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    drain();

    // zero-block pool
    set_pool(0, 1);
    send_cmd(make_cmd(fbfl_pkg::MODE_INIT, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_ALLOC, 0, 1'b0));
    send_cmd(make_cmd(fbfl_pkg::MODE_RELEASE, 0, 1'b0));
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) run_phase(counts[ph], sizes[ph]);

    $display("tb_top: %0d commands (%0d init, %0d alloc, %0d release, %0d unused mode)",
             n_by_mode[0] + n_by_mode[1] + n_by_mode[2] + n_by_mode[3],
             n_by_mode[0], n_by_mode[1], n_by_mode[2], n_by_mode[3]);
    $display("tb_top: %0d pool settings, %0d result mismatches", n_settings, errors);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
